>>> src/bdq_pkg.sv
package bdq_pkg;

  localparam int DEPTH  = 64;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int SUM_W  = CNT_W + 1;
  localparam int CMD_W  = 3;
  localparam int WORD_W = 32;
  localparam int CAP_W  = 7;
  localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  localparam logic [CAP_W-1:0]         CAP_RESET = CAP_W'(64);
  localparam logic signed [WORD_W-1:0] NONE_WORD = {WORD_W{1'b1}};

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_QUERY      = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_CAPTURE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic exec;     // request taken this cycle, apply it to the ring
    logic capture;  // load the result register from the ram read data
  } ctl_t;

  // ring position base + off, base + off below twice the depth
  function automatic addr_t ring_add(addr_t base, cnt_t off);
    logic [SUM_W-1:0] s;
    s = SUM_W'(base) + SUM_W'(off);
    if (s >= SUM_W'(DEPTH)) begin
      s = s - SUM_W'(DEPTH);
    end
    return s[ADDR_W-1:0];
  endfunction

  function automatic addr_t ring_dec(addr_t base);
    addr_t r;
    if (base == '0) begin
      r = ADDR_W'(DEPTH - 1);
    end else begin
      r = base - ADDR_W'(1);
    end
    return r;
  endfunction

endpackage

>>> src/bdq_in_if.sv
interface bdq_in_if;
  logic                                  valid;
  logic                                  ready;
  logic [bdq_pkg::CMD_W-1:0]             command;
  logic signed [bdq_pkg::WORD_W-1:0]     data_word;

  modport source (output valid, output command, output data_word, input ready);
  modport sink   (input valid, input command, input data_word, output ready);
endinterface

>>> src/bdq_out_if.sv
interface bdq_out_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  accepted;
  logic signed [bdq_pkg::WORD_W-1:0]     front_word;
  logic signed [bdq_pkg::WORD_W-1:0]     rear_word;
  logic                                  is_empty;
  logic                                  is_full;

  modport source (output valid, output accepted, output front_word, output rear_word,
                  output is_empty, output is_full, input ready);
  modport sink   (input valid, input accepted, input front_word, input rear_word,
                  input is_empty, input is_full, output ready);
endinterface

>>> src/bdq_ram.sv
module bdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr0,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr1,
  output logic [WIDTH-1:0]                          rdata0,
  output logic [WIDTH-1:0]                          rdata1
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata0_r;
  logic [WIDTH-1:0] rdata1_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata0_r <= mem[raddr0];
    rdata1_r <= mem[raddr1];
  end

  assign rdata0 = rdata0_r;
  assign rdata1 = rdata1_r;

endmodule

>>> src/bdq_ctrl.sv
module bdq_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output bdq_pkg::ctl_t ctl
);

  bdq_pkg::state_t state_r;
  bdq_pkg::state_t state_nxt;
  logic            out_full_r;
  logic            out_full_nxt;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bdq_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = bdq_pkg::ST_READ;
        end
      end
      bdq_pkg::ST_READ: begin
        state_nxt = bdq_pkg::ST_CAPTURE;
      end
      bdq_pkg::ST_CAPTURE: begin
        if (!out_full_r || out_ready) begin
          state_nxt = bdq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = bdq_pkg::ST_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    in_ready    = 1'b0;
    ctl.exec    = 1'b0;
    ctl.capture = 1'b0;
    case (state_r)
      bdq_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        ctl.exec = in_valid;
      end
      bdq_pkg::ST_CAPTURE: begin
        ctl.capture = !out_full_r || out_ready;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_comb begin
    if (ctl.capture) begin
      out_full_nxt = 1'b1;
    end else if (out_ready) begin
      out_full_nxt = 1'b0;
    end else begin
      out_full_nxt = out_full_r;
    end
  end

  assign out_valid = out_full_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= bdq_pkg::ST_IDLE;
      out_full_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      out_full_r <= out_full_nxt;
    end
  end

endmodule

>>> src/bdq_dpath.sv
module bdq_dpath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  bdq_pkg::ctl_t                     ctl,
  input  logic [bdq_pkg::CMD_W-1:0]         in_command,
  input  logic signed [bdq_pkg::WORD_W-1:0] in_data_word,
  input  logic                              cfg_we,
  input  logic [bdq_pkg::CAP_W-1:0]         cfg_wdata,
  output logic                              out_accepted,
  output logic signed [bdq_pkg::WORD_W-1:0] out_front_word,
  output logic signed [bdq_pkg::WORD_W-1:0] out_rear_word,
  output logic                              out_is_empty,
  output logic                              out_is_full
);

  bdq_pkg::addr_t            head_r;
  bdq_pkg::addr_t            head_nxt;
  bdq_pkg::cnt_t             count_r;
  bdq_pkg::cnt_t             count_nxt;
  logic [bdq_pkg::CAP_W-1:0] cap_r;
  logic                      ok_r;
  logic                      ok_nxt;

  logic                      ram_we;
  bdq_pkg::addr_t            ram_waddr;
  bdq_pkg::addr_t            rear_addr;
  logic [bdq_pkg::WORD_W-1:0] rd_front;
  logic [bdq_pkg::WORD_W-1:0] rd_rear;

  logic                      full;
  logic                      empty;

  logic                              acc_r;
  logic signed [bdq_pkg::WORD_W-1:0] front_r;
  logic signed [bdq_pkg::WORD_W-1:0] rear_r;
  logic                              empty_r;
  logic                              full_r;

  // capacity saturates at the ring depth
  assign full  = (bdq_pkg::CMP_W'(count_r) >= bdq_pkg::CMP_W'(cap_r)) ||
                 (count_r == bdq_pkg::CNT_W'(bdq_pkg::DEPTH));
  assign empty = (count_r == '0);

  always_comb begin
    head_nxt  = head_r;
    count_nxt = count_r;
    ok_nxt    = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = bdq_pkg::ring_add(head_r, count_r);
    case (bdq_pkg::cmd_t'(in_command))
      bdq_pkg::CMD_PUSH_FRONT: begin
        ram_waddr = bdq_pkg::ring_dec(head_r);
        if (!full) begin
          head_nxt  = bdq_pkg::ring_dec(head_r);
          count_nxt = count_r + bdq_pkg::CNT_W'(1);
          ram_we    = ctl.exec;
          ok_nxt    = 1'b1;
        end
      end
      bdq_pkg::CMD_PUSH_BACK: begin
        if (!full) begin
          count_nxt = count_r + bdq_pkg::CNT_W'(1);
          ram_we    = ctl.exec;
          ok_nxt    = 1'b1;
        end
      end
      bdq_pkg::CMD_POP_FRONT: begin
        if (!empty) begin
          head_nxt  = bdq_pkg::ring_add(head_r, bdq_pkg::CNT_W'(1));
          count_nxt = count_r - bdq_pkg::CNT_W'(1);
          ok_nxt    = 1'b1;
        end
      end
      bdq_pkg::CMD_POP_BACK: begin
        if (!empty) begin
          count_nxt = count_r - bdq_pkg::CNT_W'(1);
          ok_nxt    = 1'b1;
        end
      end
      bdq_pkg::CMD_QUERY: begin
        ok_nxt = 1'b1;
      end
      default: begin
        ok_nxt = 1'b0;
      end
    endcase
  end

  // only meaningful when not empty
  assign rear_addr = bdq_pkg::ring_add(head_r, count_r - bdq_pkg::CNT_W'(1));

  bdq_ram #(
    .WIDTH (bdq_pkg::WORD_W),
    .DEPTH (bdq_pkg::DEPTH)
  ) u_ram (
    .clk    (clk),
    .we     (ram_we),
    .waddr  (ram_waddr),
    .wdata  (in_data_word),
    .raddr0 (head_r),
    .raddr1 (rear_addr),
    .rdata0 (rd_front),
    .rdata1 (rd_rear)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
      cap_r   <= bdq_pkg::CAP_RESET;
    end else begin
      if (ctl.exec) begin
        head_r  <= head_nxt;
        count_r <= count_nxt;
      end
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.exec) begin
      ok_r <= ok_nxt;
    end
    if (ctl.capture) begin
      acc_r   <= ok_r;
      front_r <= empty ? bdq_pkg::NONE_WORD : rd_front;
      rear_r  <= empty ? bdq_pkg::NONE_WORD : rd_rear;
      empty_r <= empty;
      full_r  <= full;
    end
  end

  assign out_accepted   = acc_r;
  assign out_front_word = front_r;
  assign out_rear_word  = rear_r;
  assign out_is_empty   = empty_r;
  assign out_is_full    = full_r;

endmodule

>>> src/bounded_double_ended_queue_unit.sv
// channel    dir  handshake          payload
// in_chan    in   valid / ready      command, data_word
// out_chan   out  valid / ready      accepted, front_word, rear_word, is_empty, is_full
// cfg        in   cfg_we             cfg_wdata (capacity)
//
// one request in flight at a time: accept (ring update and ram write), ram read of
//   the new front and rear, then capture into the result register
// the result shows on out_chan the cycle after capture; a result still waiting
//   there does not block the next request, only its capture
// rst_n is synchronous, active low: empty ring, head 0, capacity 64
// ram contents are not cleared; entries outside the occupied span are never shown
module bounded_double_ended_queue_unit (
  input  logic                      clk,
  input  logic                      rst_n,
  bdq_in_if.sink                    in_chan,
  bdq_out_if.source                 out_chan,
  input  logic                      cfg_we,
  input  logic [bdq_pkg::CAP_W-1:0] cfg_wdata
);

  bdq_pkg::ctl_t ctl;

  // sequencer: idle / read / capture plus result-register occupancy
  bdq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .ctl       (ctl)
  );

  // ring pointers, capacity register, entry ram and result register
  bdq_dpath u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctl            (ctl),
    .in_command     (in_chan.command),
    .in_data_word   (in_chan.data_word),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .out_accepted   (out_chan.accepted),
    .out_front_word (out_chan.front_word),
    .out_rear_word  (out_chan.rear_word),
    .out_is_empty   (out_chan.is_empty),
    .out_is_full    (out_chan.is_full)
  );

  // a new result only appears right after a capture
  a_rise_after_capture: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_chan.valid) |-> $past(ctl.capture))
    else $error("result shown without capture");

  // block is busy for the cycle after taking a request
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.exec |=> !in_chan.ready)
    else $error("request taken while previous one in flight");

  // an empty queue reports the empty marker on both ends
  a_empty_marker: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.is_empty) |->
      (out_chan.front_word == bdq_pkg::NONE_WORD &&
       out_chan.rear_word == bdq_pkg::NONE_WORD))
    else $error("empty result with stale words");

endmodule

>>> test/bounded_double_ended_queue_unit_test.sv
module bounded_double_ended_queue_unit_test;
  import bdq_pkg::*;

  localparam int LIMIT_CYCLES  = 200000;
  localparam int SETTLE_CYCLES = 12;
  localparam int HOLD_CYCLES   = 300;
  localparam int PHASE_ITEMS   = 195;
  localparam int IDLE_HEAVY    = 56;
  localparam int IDLE_LIGHT    = 18;
  localparam int PRINT_LIMIT   = 40;
  localparam int CMD_MAX_CODE  = (1 << CMD_W) - 1;

  localparam logic [WORD_W-1:0] WORD_MAX = 32'h7fff_ffff;
  localparam logic [WORD_W-1:0] WORD_MIN = 32'h8000_0000;

  typedef struct {
    logic [CMD_W-1:0]  command;
    logic [WORD_W-1:0] data_word;
  } request_t;

  typedef struct {
    logic              accepted;
    logic [WORD_W-1:0] front_word;
    logic [WORD_W-1:0] rear_word;
    logic              is_empty;
    logic              is_full;
  } deque_status_t;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             cfg_we;
  logic [CAP_W-1:0] cfg_wdata;

  bdq_in_if  in_chan ();
  bdq_out_if out_chan ();

  bounded_double_ended_queue_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // shadow copy of the deque: ring, head, count and the capacity register
  logic [WORD_W-1:0] ring_mem [DEPTH];
  int                ring_head = 0;
  int                ring_count = 0;
  int                cap_reg = int'(CAP_RESET);

  request_t      cmd_backlog [$];   // requests waiting to be offered
  deque_status_t status_due [$];    // predicted status, oldest first
  int            results_owed = 0;  // requests queued whose status has not come back
  int            results_seen = 0;
  int            fail_count = 0;
  int            cycle_count = 0;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  // long receiver hold-off, armed from the stimulus process
  int hold_arm = 0;
  int hold_taken = 0;
  int hold_left = 0;

  int phase_caps [9] = '{64, 127, 5, 1, 0, 33, 2, 100, 64};

  // apply one request to the shadow deque and return the status it should report
  function automatic deque_status_t deque_apply(logic [CMD_W-1:0] code,
                                                logic [WORD_W-1:0] word);
    deque_status_t st;
    int            limit;
    bit            was_full;
    bit            was_empty;
    limit = (cap_reg > DEPTH) ? DEPTH : cap_reg;  // capacity saturates at the ring size
    was_full = ring_count >= limit;
    was_empty = ring_count == 0;
    st.accepted = 1'b0;
    case (code)
      CMD_PUSH_FRONT: begin
        if (!was_full) begin
          ring_head = (ring_head + DEPTH - 1) % DEPTH;
          ring_mem[ring_head] = word;
          ring_count++;
          st.accepted = 1'b1;
        end
      end
      CMD_PUSH_BACK: begin
        if (!was_full) begin
          ring_mem[(ring_head + ring_count) % DEPTH] = word;
          ring_count++;
          st.accepted = 1'b1;
        end
      end
      CMD_POP_FRONT: begin
        if (!was_empty) begin
          ring_head = (ring_head + 1) % DEPTH;
          ring_count--;
          st.accepted = 1'b1;
        end
      end
      CMD_POP_BACK: begin
        if (!was_empty) begin
          ring_count--;
          st.accepted = 1'b1;
        end
      end
      CMD_QUERY: st.accepted = 1'b1;
      default: st.accepted = 1'b0;  // unknown codes leave the deque alone
    endcase
    st.is_empty = ring_count == 0;
    st.is_full = ring_count >= limit;
    st.front_word = st.is_empty ? NONE_WORD : ring_mem[ring_head];
    st.rear_word = st.is_empty ? NONE_WORD : ring_mem[(ring_head + ring_count - 1) % DEPTH];
    return st;
  endfunction

  // word to push, extremes now and then
  function automatic logic [WORD_W-1:0] pick_word();
    logic [WORD_W-1:0] w;
    case ($urandom_range(15))
      0: w = WORD_MAX;
      1: w = WORD_MIN;
      2: w = '1;
      3: w = '0;
      default: w = $urandom;
    endcase
    return w;
  endfunction

  // random request: a few unknown codes and queries, else pushes taken with the given percentage among pushes and pops
  function automatic request_t pick_request(int push_pct);
    request_t r;
    int       roll;
    roll = $urandom_range(99);
    if (roll < 4) begin
      r.command = CMD_W'($urandom_range(CMD_MAX_CODE, CMD_QUERY + 1));
    end else if (roll < 12) begin
      r.command = CMD_QUERY;
    end else if ($urandom_range(99) < push_pct) begin
      r.command = $urandom_range(1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
    end else begin
      r.command = $urandom_range(1) ? CMD_POP_BACK : CMD_POP_FRONT;
    end
    r.data_word = pick_word();
    return r;
  endfunction

  task automatic queue_request(logic [CMD_W-1:0] code, logic [WORD_W-1:0] word);
    request_t r;
    r.command = code;
    r.data_word = word;
    cmd_backlog.push_back(r);
    results_owed++;
  endtask

  // random traffic in runs that lean toward filling, draining or neither
  task automatic queue_random_traffic(int n_items);
    int run_left;
    int push_pct;
    // open with a fill run so the deque reaches full at any capacity
    run_left = 2 * DEPTH;
    push_pct = 95;
    for (int i = 0; i < n_items; i++) begin
      if (run_left == 0) begin
        run_left = $urandom_range(150, 15);
        case ($urandom_range(2))
          0: push_pct = 90;
          1: push_pct = 10;
          default: push_pct = 50;
        endcase
      end
      run_left--;
      cmd_backlog.push_back(pick_request(push_pct));
      results_owed++;
    end
  endtask

  // let every request come back, then give the block time to go quiet
  task automatic wait_drained();
    while (results_owed != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // register write, only while the block is idle
  task automatic set_capacity(int value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= CAP_W'(value);
    @(posedge clk);
    cfg_we <= 1'b0;
    cap_reg = value & ((1 << CAP_W) - 1);
  endtask

  task automatic report_mismatch(string field, logic [WORD_W-1:0] got,
                                 logic [WORD_W-1:0] want);
    if (fail_count < PRINT_LIMIT) begin
      $display("status %0d: %s is %h, want %h", results_seen, field, got, want);
    end
    fail_count++;
  endtask

  // request driver: offers the backlog, holds a request until it is taken
  always @(posedge clk) begin : drive_requests
    request_t next_req;
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
      in_chan.command <= '0;
      in_chan.data_word <= '0;
    end else begin
      // a request taken at this edge updates the shadow deque in order
      if (in_chan.valid && in_chan.ready) begin
        status_due.push_back(deque_apply(in_chan.command, in_chan.data_word));
      end
      if (in_chan.valid && !in_chan.ready) begin
        // stalled, keep the request on the bus
      end else if (cmd_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_req = cmd_backlog.pop_front();
        in_chan.valid <= 1'b1;
        in_chan.command <= next_req.command;
        in_chan.data_word <= next_req.data_word;
      end else begin
        // idle, junk on the payload
        in_chan.valid <= 1'b0;
        in_chan.command <= CMD_W'($urandom);
        in_chan.data_word <= $urandom;
      end
    end
  end

  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_taken != hold_arm) begin
      hold_left <= HOLD_CYCLES;
      hold_taken <= hold_arm;
    end
  end

  // status monitor: checks each returned status against the oldest prediction
  always @(posedge clk) begin : check_status
    deque_status_t want;
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        if (status_due.size() == 0) begin
          if (fail_count < PRINT_LIMIT) begin
            $display("status %0d arrived with no request waiting", results_seen);
          end
          fail_count++;
        end else begin
          want = status_due.pop_front();
          if (out_chan.accepted !== want.accepted) begin
            report_mismatch("accepted", WORD_W'(out_chan.accepted), WORD_W'(want.accepted));
          end
          if (out_chan.front_word !== want.front_word) begin
            report_mismatch("front_word", out_chan.front_word, want.front_word);
          end
          if (out_chan.rear_word !== want.rear_word) begin
            report_mismatch("rear_word", out_chan.rear_word, want.rear_word);
          end
          if (out_chan.is_empty !== want.is_empty) begin
            report_mismatch("is_empty", WORD_W'(out_chan.is_empty), WORD_W'(want.is_empty));
          end
          if (out_chan.is_full !== want.is_full) begin
            report_mismatch("is_full", WORD_W'(out_chan.is_full), WORD_W'(want.is_full));
          end
          results_owed--;
        end
        results_seen++;
      end
      out_chan.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // watchdog
  initial begin
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("simulation failed");
    $finish;
  end

  initial begin
    int cap;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_chan.valid = 1'b0;
    in_chan.command = '0;
    in_chan.data_word = '0;
    out_chan.ready = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty deque at reset capacity: query and refused pops
    queue_request(CMD_QUERY, '0);
    queue_request(CMD_POP_FRONT, '0);
    queue_request(CMD_POP_BACK, '0);
    // extremes pushed at both ends
    queue_request(CMD_PUSH_BACK, WORD_MAX);
    queue_request(CMD_PUSH_FRONT, WORD_MIN);
    queue_request(CMD_PUSH_BACK, '0);
    queue_request(CMD_PUSH_FRONT, '1);
    // unknown codes change nothing and report the deque
    queue_request(CMD_W'(CMD_QUERY + 1), WORD_MAX);
    queue_request(CMD_W'(CMD_MAX_CODE), WORD_MIN);
    queue_request(CMD_POP_FRONT, '0);
    queue_request(CMD_POP_BACK, '0);
    wait_drained();

    // two entries at capacity two: full, push refused; a pop back then makes room for a push front
    set_capacity(2);
    queue_request(CMD_PUSH_BACK, 32'h1234_5678);
    queue_request(CMD_POP_BACK, '0);
    queue_request(CMD_PUSH_FRONT, 32'h5a5a_5a5a);
    wait_drained();

    // capacity dropped below the count: still full, pops work
    set_capacity(1);
    queue_request(CMD_PUSH_BACK, 32'ha5a5_a5a5);
    queue_request(CMD_POP_FRONT, '0);
    queue_request(CMD_POP_BACK, '0);
    wait_drained();

    // capacity zero: empty and full at once, every push refused
    set_capacity(0);
    queue_request(CMD_PUSH_FRONT, WORD_MAX);
    queue_request(CMD_PUSH_BACK, WORD_MIN);
    queue_request(CMD_QUERY, '0);
    wait_drained();

    // capacity above the ring size saturates
    set_capacity((1 << CAP_W) - 1);
    queue_request(CMD_PUSH_BACK, 32'h0000_0001);
    queue_request(CMD_POP_FRONT, '0);
    wait_drained();

    // random phases over capacities and idle patterns
    for (int p = 0; p < 9; p++) begin
      cap = (p == 8) ? $urandom_range(DEPTH, 1) : phase_caps[p];
      set_capacity(cap);
      case (p % 4)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
          // receiver holds off while requests keep coming, so the block backs up
          hold_arm <= hold_arm + 1;
        end
        1: begin
          send_idle_pct = IDLE_HEAVY;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = IDLE_HEAVY;
        end
        default: begin
          send_idle_pct = IDLE_LIGHT;
          recv_stall_pct = IDLE_LIGHT;
        end
      endcase
      queue_random_traffic(PHASE_ITEMS);
      // sender pauses here until every status is back
      wait_drained();
    end

    if (status_due.size() != 0) begin
      $display("%0d predicted statuses never arrived", status_due.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> bounded_double_ended_queue_unit.f
src/bdq_pkg.sv
src/bdq_in_if.sv
src/bdq_out_if.sv
src/bdq_ram.sv
src/bdq_ctrl.sv
src/bdq_dpath.sv
src/bounded_double_ended_queue_unit.sv
test/bounded_double_ended_queue_unit_test.sv
